/* rtl/cbr_pkg.sv */
`timescale 1ns / 1ps

package cbr_pkg;

  // Scheme dimensions
  localparam int MAX_LEVELS = 256;
  localparam int MAX_GAMMAS = 512;
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int GAM_W      = $clog2(MAX_GAMMAS);
  localparam int NL_W       = LVL_W + 1;
  localparam int NG_W       = GAM_W + 1;
  localparam int MAT_AW     = LVL_W + GAM_W;

  // Arithmetic
  localparam int DATA_W     = 24;
  localparam int COEFF_P1_W = DATA_W + 1;
  localparam int WGT_W      = DATA_W + COEFF_P1_W;
  localparam int SUM_W      = 64;
  localparam int FRAC_BITS  = 23;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ADD_W      = PROD_W - FRAC_BITS + 1;
  localparam int ONE_SHIFT  = 16;
  localparam logic [COEFF_P1_W-1:0] COEFF_ONE = COEFF_P1_W'(1 << ONE_SHIFT);
  localparam logic [DATA_W-1:0]     RATIO_MAX = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_COUNT = CFG_IDX_W'(1);
  localparam int LCNT_W = 9;
  localparam int GCNT_W = 10;

  typedef enum logic [1:0] {
    OP_LEVEL   = 2'd0,
    OP_GAMMA   = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DONE, ST_INIT,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
    ST_WALK, ST_W0, ST_W1, ST_S0, ST_S1, ST_S2,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4,
    ST_C0, ST_C1, ST_C2, ST_NEXT_G, ST_NEXT_L
  } state_e;

  typedef struct packed {
    op_e               operation;
    logic [LVL_W-1:0]  level_index;
    logic [GAM_W-1:0]  gamma_index;
    logic [LVL_W-1:0]  final_level;
    logic [DATA_W-1:0] level_energy;
    logic [DATA_W-1:0] intensity;
    logic [DATA_W-1:0] conversion_coeff;
    logic              sort_first;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] ratio;
    logic              status;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] intensity;
    logic [DATA_W-1:0] coeff;
    logic [LVL_W-1:0]  src_level;
    logic [LVL_W-1:0]  tgt_level;
  } gamma_t;

endpackage

/* rtl/cbr_if.sv */
`timescale 1ns / 1ps

// Input item channel
interface cbr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  level_index;
  logic [8:0]  gamma_index;
  logic [7:0]  final_level;
  logic [23:0] level_energy;
  logic [23:0] intensity;
  logic [23:0] conversion_coeff;
  logic        sort_first;

  modport source (output valid, operation, level_index, gamma_index, final_level,
                  level_energy, intensity, conversion_coeff, sort_first, input ready);
  modport sink   (input valid, operation, level_index, gamma_index, final_level,
                  level_energy, intensity, conversion_coeff, sort_first, output ready);
endinterface

// Result item channel
interface cbr_result_if;
  logic        valid;
  logic        ready;
  logic [23:0] ratio;
  logic        status;

  modport source (output valid, ratio, status, input ready);
  modport sink   (input valid, ratio, status, output ready);
endinterface

// Configuration write channel
interface cbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/cascade_branching_ratio_engine.sv */
`timescale 1ns / 1ps

// Cascade branching-ratio engine.
// item_i carries load, compute and read items; result_o returns exactly one
// result item per input item, in order; cfg_i writes level_count (index 0)
// and gamma_count (index 1) and is always ready; write it only while idle.
// Level and gamma writes go straight to the result register; a read
// first passes through one matrix memory read. One item is worked on at a time.
// A compute zeroes the 131072-entry ratio matrix, one entry a cycle, then
// optionally bubble-sorts the levels (up to nl passes), then walks the
// levels: one pass over the gammas for each level sum, and for every
// gamma leaving the level two divisions plus one pass over the gammas for
// the column update. Its result follows the walk.
// After reset the same clearing pass runs and also sets the level order to
// the identity; item_i.ready stays low until it ends.
// The result sits in an output register; while the receiver stalls the
// next item is still taken, and its result waits in the sequencer.
module cascade_branching_ratio_engine (
  input logic         clk_i,
  input logic         rst_ni,
  cbr_item_if.sink    item_i,
  cbr_result_if.source result_o,
  cbr_cfg_if.sink     cfg_i
);
  import cbr_pkg::*;

  logic [LCNT_W-1:0] level_count_q;
  logic [GCNT_W-1:0] gamma_count_q;
  logic [NL_W-1:0]   nl;
  logic [NG_W-1:0]   ng;
  item_t             item;
  logic              core_ready, res_valid, res_take;
  result_t           res, out_q;
  logic              out_vld_q;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= '0;
      gamma_count_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_LEVEL_COUNT) begin
        level_count_q <= cfg_i.data[LCNT_W-1:0];
      end
      if (cfg_i.index == CFG_GAMMA_COUNT) begin
        gamma_count_q <= cfg_i.data[GCNT_W-1:0];
      end
    end
  end

  // Counts in use, clamped to the store sizes
  assign nl = (NL_W'(level_count_q) > NL_W'(MAX_LEVELS)) ? NL_W'(MAX_LEVELS)
                                                          : NL_W'(level_count_q);
  assign ng = (NG_W'(gamma_count_q) > NG_W'(MAX_GAMMAS)) ? NG_W'(MAX_GAMMAS)
                                                          : NG_W'(gamma_count_q);

  assign item = '{operation:        op_e'(item_i.operation),
                  level_index:      item_i.level_index,
                  gamma_index:      item_i.gamma_index,
                  final_level:      item_i.final_level,
                  level_energy:     item_i.level_energy,
                  intensity:        item_i.intensity,
                  conversion_coeff: item_i.conversion_coeff,
                  sort_first:       item_i.sort_first};

  assign item_i.ready = core_ready;

  cbr_core u_core (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_i.valid),
    .item_i       (item),
    .item_ready_o (core_ready),
    .nl_i         (nl),
    .ng_i         (ng),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take)
  );

  // Output register
  assign res_take = !out_vld_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign result_o.valid  = out_vld_q;
  assign result_o.ratio  = out_q.ratio;
  assign result_o.status = out_q.status;

endmodule

/* rtl/cbr_ram.sv */
`timescale 1ns / 1ps

module cbr_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/cbr_div.sv */
`timescale 1ns / 1ps

// Restoring fraction divider: floor(num * 2^23 / den) for num <= den,
// one quotient bit a cycle
module cbr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cbr_pkg::SUM_W-1:0]  num_i,
  input  logic [cbr_pkg::SUM_W-1:0]  den_i,
  output logic                       done_o,
  output logic [cbr_pkg::DATA_W-1:0] quot_o
);
  import cbr_pkg::*;

  logic                 busy_q, busy_d, done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]     rem_q, rem_d, trial;
  logic [DATA_W-1:0]    quot_q, quot_d;
  logic                 ge;

  assign trial = (cnt_q == '0) ? rem_q : {rem_q[SUM_W-2:0], 1'b0};
  assign ge    = (trial >= den_i);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      quot_d = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[DATA_W-2:0], ge};
      rem_d  = ge ? (trial - den_i) : trial;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/cbr_core.sv */
`timescale 1ns / 1ps

// Sequencer around the scheme memories and the ratio matrix
module cbr_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  cbr_pkg::item_t           item_i,
  output logic                     item_ready_o,
  input  logic [cbr_pkg::NL_W-1:0] nl_i,
  input  logic [cbr_pkg::NG_W-1:0] ng_i,
  output logic                     res_valid_o,
  output cbr_pkg::result_t         res_o,
  input  logic                     res_take_i
);
  import cbr_pkg::*;

  state_e            state_q, state_d;
  logic [MAT_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_order_q, clr_order_d;
  logic              cmp_q, cmp_d, sort_q, sort_d, swapped_q, swapped_d;
  logic [NL_W-1:0]   lvl_i_q, lvl_i_d, lvl_nx;
  logic [NG_W-1:0]   g_q, g_d, g_nx, jj_q, jj_d, jj_nx;
  logic [LVL_W-1:0]  li_q, li_d, lf_q, lf_d, carry_q, carry_d, b_q, b_d;
  logic [DATA_W-1:0] carry_e_q, carry_e_d, gint_q, gint_d, scale_q, scale_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [WGT_W-1:0]  w_q, w_d;
  logic              match_q, match_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  result_t           res_q, res_d;

  // Memory ports
  logic              en_we, ord_we, gam_we, mat_we;
  logic [LVL_W-1:0]  en_waddr, en_raddr, ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [DATA_W-1:0] en_wdata, en_rdata, mat_wdata, mat_rdata;
  logic [GAM_W-1:0]  gam_waddr, gam_raddr;
  gamma_t            gam_wdata, gam_rdata;
  logic [MAT_AW-1:0] mat_waddr, mat_raddr;

  // Divider
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_num;
  logic [DATA_W-1:0] div_q;

  logic [COEFF_P1_W-1:0] coeff_p1;
  logic [WGT_W-1:0]      w_calc;
  logic [ADD_W-1:0]      acc;
  logic [NL_W-1:0]       nl_m1;

  cbr_ram #(.DEPTH(MAX_LEVELS), .WIDTH(DATA_W)) u_energy (
    .clk_i, .we_i(en_we), .waddr_i(en_waddr), .wdata_i(en_wdata),
    .raddr_i(en_raddr), .rdata_o(en_rdata)
  );

  cbr_ram #(.DEPTH(MAX_LEVELS), .WIDTH(LVL_W)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  cbr_ram #(.DEPTH(MAX_GAMMAS), .WIDTH($bits(gamma_t))) u_gamma (
    .clk_i, .we_i(gam_we), .waddr_i(gam_waddr), .wdata_i(gam_wdata),
    .raddr_i(gam_raddr), .rdata_o(gam_rdata)
  );

  cbr_ram #(.DEPTH(MAX_LEVELS * MAX_GAMMAS), .WIDTH(DATA_W)) u_matrix (
    .clk_i, .we_i(mat_we), .waddr_i(mat_waddr), .wdata_i(mat_wdata),
    .raddr_i(mat_raddr), .rdata_o(mat_rdata)
  );

  cbr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(sum_q),
    .done_o(div_done), .quot_o(div_q)
  );

  // Weight of the gamma just read: I * (C + 1.0)
  assign coeff_p1 = {1'b0, gam_rdata.coeff} + COEFF_ONE;
  assign w_calc   = WGT_W'(gam_rdata.intensity) * WGT_W'(coeff_p1);
  assign acc      = ADD_W'(mat_rdata) + ADD_W'(prod_q[PROD_W-1:FRAC_BITS]);
  assign lvl_nx   = lvl_i_q + 1'b1;
  assign g_nx     = g_q + 1'b1;
  assign jj_nx    = jj_q + 1'b1;
  assign nl_m1    = nl_i - 1'b1;

  assign item_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = (state_q == ST_DONE);
  assign res_o        = res_q;

  // Next state and memory control
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_order_d = clr_order_q;
    cmp_d       = cmp_q;
    sort_d      = sort_q;
    swapped_d   = swapped_q;
    lvl_i_d     = lvl_i_q;
    g_d         = g_q;
    jj_d        = jj_q;
    li_d        = li_q;
    lf_d        = lf_q;
    carry_d     = carry_q;
    carry_e_d   = carry_e_q;
    b_d         = b_q;
    gint_d      = gint_q;
    scale_d     = scale_q;
    sum_d       = sum_q;
    w_d         = w_q;
    match_d     = match_q;
    prod_d      = prod_q;
    res_d       = res_q;
    en_we = 1'b0; en_waddr = item_i.level_index; en_wdata = item_i.level_energy;
    en_raddr  = '0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    gam_we = 1'b0; gam_waddr = item_i.gamma_index; gam_raddr = '0;
    gam_wdata = '{intensity: item_i.intensity, coeff: item_i.conversion_coeff,
                  src_level: item_i.level_index, tgt_level: item_i.final_level};
    mat_we = 1'b0; mat_waddr = '0; mat_wdata = '0; mat_raddr = '0;
    div_start = 1'b0;
    div_num   = '0;

    case (state_q)
      // Zero the matrix, and after reset also set the identity order
      ST_CLEAR: begin
        mat_we    = 1'b1;
        mat_waddr = clr_cnt_q;
        if (clr_order_q && (clr_cnt_q[MAT_AW-1:LVL_W] == '0)) begin
          ord_we    = 1'b1;
          ord_waddr = clr_cnt_q[LVL_W-1:0];
          ord_wdata = clr_cnt_q[LVL_W-1:0];
        end
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          clr_order_d = 1'b0;
          cmp_d       = 1'b0;
          lvl_i_d     = '0;
          if (!cmp_q) begin
            state_d = ST_IDLE;
          end else if (sort_q) begin
            state_d = ST_INIT;
          end else begin
            state_d = ST_WALK;
          end
        end
      end

      ST_IDLE: begin
        if (item_valid_i) begin
          res_d   = '0;
          state_d = ST_DONE;
          case (item_i.operation)
            OP_LEVEL: begin
              if ({1'b0, item_i.level_index} < nl_i) begin
                en_we = 1'b1;
              end else begin
                res_d.status = 1'b1;
              end
            end
            OP_GAMMA: begin
              if ({1'b0, item_i.gamma_index} < ng_i) begin
                gam_we = 1'b1;
              end else begin
                res_d.status = 1'b1;
              end
            end
            OP_COMPUTE: begin
              cmp_d     = 1'b1;
              sort_d    = item_i.sort_first;
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
            OP_READ: begin
              if (({1'b0, item_i.level_index} < nl_i) &&
                  ({1'b0, item_i.gamma_index} < ng_i)) begin
                mat_raddr = {item_i.gamma_index, item_i.level_index};
                state_d   = ST_READ;
              end else begin
                res_d.status = 1'b1;
              end
            end
            default: res_d.status = 1'b1;
          endcase
        end
      end

      ST_READ: begin
        res_d.ratio = mat_rdata;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      // Identity order over the levels in use
      ST_INIT: begin
        if (lvl_i_q < nl_i) begin
          ord_we    = 1'b1;
          ord_waddr = lvl_i_q[LVL_W-1:0];
          ord_wdata = lvl_i_q[LVL_W-1:0];
          lvl_i_d   = lvl_nx;
        end else if (nl_i >= NL_W'(2)) begin
          state_d = ST_P0;
        end else begin
          state_d = ST_WALK;
        end
      end

      // One bubble pass: the larger element travels in carry
      ST_P0: begin
        ord_raddr = '0;
        state_d   = ST_P1;
      end
      ST_P1: begin
        carry_d  = ord_rdata;
        en_raddr = ord_rdata;
        state_d  = ST_P2;
      end
      ST_P2: begin
        carry_e_d = en_rdata;
        lvl_i_d   = NL_W'(1);
        swapped_d = 1'b0;
        state_d   = ST_P3;
      end
      ST_P3: begin
        ord_raddr = lvl_i_q[LVL_W-1:0];
        state_d   = ST_P4;
      end
      ST_P4: begin
        b_d      = ord_rdata;
        en_raddr = ord_rdata;
        state_d  = ST_P5;
      end
      ST_P5: begin
        ord_we    = 1'b1;
        ord_waddr = lvl_i_q[LVL_W-1:0] - 1'b1;
        if (carry_e_q > en_rdata) begin
          ord_wdata = b_q;
          swapped_d = 1'b1;
        end else begin
          ord_wdata = carry_q;
          carry_d   = b_q;
          carry_e_d = en_rdata;
        end
        lvl_i_d = lvl_nx;
        state_d = (lvl_nx < nl_i) ? ST_P3 : ST_P6;
      end
      ST_P6: begin
        ord_we    = 1'b1;
        ord_waddr = nl_m1[LVL_W-1:0];
        ord_wdata = carry_q;
        state_d   = swapped_q ? ST_P0 : ST_WALK;
      end

      // Level walk, lowest in order skipped
      ST_WALK: begin
        lvl_i_d = NL_W'(1);
        state_d = (nl_i >= NL_W'(2)) ? ST_W0 : ST_DONE;
      end
      ST_W0: begin
        ord_raddr = lvl_i_q[LVL_W-1:0];
        state_d   = ST_W1;
      end
      ST_W1: begin
        li_d    = ord_rdata;
        g_d     = '0;
        sum_d   = '0;
        state_d = (ng_i == '0) ? ST_NEXT_L : ST_S0;
      end

      // Sum of weights leaving this level
      ST_S0: begin
        gam_raddr = g_q[GAM_W-1:0];
        state_d   = ST_S1;
      end
      ST_S1, ST_B1: begin
        w_d     = w_calc;
        match_d = (gam_rdata.src_level == li_q);
        gint_d  = gam_rdata.intensity;
        lf_d    = gam_rdata.tgt_level;
        state_d = (state_q == ST_S1) ? ST_S2 : ST_B2;
      end
      ST_S2: begin
        if (match_q) begin
          sum_d = sum_q + SUM_W'(w_q);
        end
        g_d = g_nx;
        if (g_nx < ng_i) begin
          state_d = ST_S0;
        end else if (sum_d == '0) begin
          state_d = ST_NEXT_L;
        end else begin
          g_d     = '0;
          state_d = ST_B0;
        end
      end

      // Per gamma: own ratio, then scale and column add
      ST_B0: begin
        gam_raddr = g_q[GAM_W-1:0];
        state_d   = ST_B1;
      end
      ST_B2: begin
        if (!match_q) begin
          state_d = ST_NEXT_G;
        end else begin
          div_start = 1'b1;
          div_num   = SUM_W'({gint_q, ONE_SHIFT'(0)});
          state_d   = ST_B3;
        end
      end
      ST_B3: begin
        if (div_done) begin
          mat_we    = 1'b1;
          mat_waddr = {g_q[GAM_W-1:0], li_q};
          mat_wdata = div_q;
          div_start = 1'b1;
          div_num   = SUM_W'(w_q);
          state_d   = ST_B4;
        end
      end
      ST_B4: begin
        if (div_done) begin
          scale_d = div_q;
          jj_d    = '0;
          state_d = ST_C0;
        end
      end
      ST_C0: begin
        mat_raddr = {jj_q[GAM_W-1:0], lf_q};
        state_d   = ST_C1;
      end
      ST_C1: begin
        prod_d    = PROD_W'(mat_rdata) * PROD_W'(scale_q);
        mat_raddr = {jj_q[GAM_W-1:0], li_q};
        state_d   = ST_C2;
      end
      ST_C2: begin
        mat_we    = 1'b1;
        mat_waddr = {jj_q[GAM_W-1:0], li_q};
        mat_wdata = (acc > ADD_W'(RATIO_MAX)) ? RATIO_MAX : acc[DATA_W-1:0];
        jj_d      = jj_nx;
        state_d   = (jj_nx < ng_i) ? ST_C0 : ST_NEXT_G;
      end
      ST_NEXT_G: begin
        g_d     = g_nx;
        state_d = (g_nx < ng_i) ? ST_B0 : ST_NEXT_L;
      end
      ST_NEXT_L: begin
        lvl_i_d = lvl_nx;
        state_d = (lvl_nx < nl_i) ? ST_W0 : ST_DONE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_order_q <= 1'b1;
      cmp_q       <= 1'b0;
      sort_q      <= 1'b0;
      swapped_q   <= 1'b0;
      lvl_i_q     <= '0;
      g_q         <= '0;
      jj_q        <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_order_q <= clr_order_d;
      cmp_q       <= cmp_d;
      sort_q      <= sort_d;
      swapped_q   <= swapped_d;
      lvl_i_q     <= lvl_i_d;
      g_q         <= g_d;
      jj_q        <= jj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    li_q      <= li_d;
    lf_q      <= lf_d;
    carry_q   <= carry_d;
    carry_e_q <= carry_e_d;
    b_q       <= b_d;
    gint_q    <= gint_d;
    scale_q   <= scale_d;
    sum_q     <= sum_d;
    w_q       <= w_d;
    match_q   <= match_d;
    prod_q    <= prod_d;
    res_q     <= res_d;
  end

endmodule

/* rtl/cbr_checker.sv */
`timescale 1ns / 1ps

module cbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] out_ratio_i,
  input logic        out_status_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_ratio_i) && $stable(out_status_i))
    else $error("result changed while stalled");

  // An error result carries no ratio
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_ratio_i == 24'd0)
    else $error("nonzero ratio with error status");

  // One item at a time: no accept straight after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while busy");

endmodule

bind cascade_branching_ratio_engine cbr_checker u_cbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_ratio_i  (result_o.ratio),
  .out_status_i (result_o.status)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import cbr_pkg::*;

  localparam int IDLE_LIMIT = 600000;
  localparam int ITEM_GOAL  = 1200;

  logic clk_i;
  logic rst_ni;

  cbr_item_if   item_if();
  cbr_result_if res_if();
  cbr_cfg_if    cfg_if();

  cascade_branching_ratio_engine u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Shadow copy of the scheme
  logic [8:0]        lvl_count;
  logic [9:0]        gam_count;
  logic [DATA_W-1:0] energy_mem [MAX_LEVELS];
  logic [LVL_W-1:0]  order_mem  [MAX_LEVELS];
  gamma_t            gamma_mem  [MAX_GAMMAS];
  logic [DATA_W-1:0] ratio_mem  [MAX_GAMMAS*MAX_LEVELS];

  result_t pending_q[$];
  int      n_errors;
  int      n_mismatch;
  int      n_sent;
  int      burst_left;
  int      idle_cycles = 0;

  function automatic int eff_levels();
    return (lvl_count < MAX_LEVELS) ? int'(lvl_count) : MAX_LEVELS;
  endfunction

  function automatic int eff_gammas();
    return (gam_count < MAX_GAMMAS) ? int'(gam_count) : MAX_GAMMAS;
  endfunction

  function automatic logic [63:0] gamma_weight(int g);
    logic [63:0] ic;
    logic [63:0] cc;
    ic = 64'(gamma_mem[g].intensity);
    cc = 64'(gamma_mem[g].coeff) + 64'(COEFF_ONE);
    return ic * cc;
  endfunction

  // floor(num * 2^23 / den), num <= den
  function automatic logic [DATA_W-1:0] ratio_div(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
    return q[DATA_W-1:0];
  endfunction

  // Clear, optional stable sort, then the upward walk
  function automatic void walk_scheme(bit do_sort);
    int nl;
    int ng;
    bit swapped;
    logic [LVL_W-1:0] a;
    logic [LVL_W-1:0] b;
    logic [LVL_W-1:0] li;
    logic [LVL_W-1:0] lf;
    logic [63:0] sum;
    logic [63:0] add;
    logic [63:0] v;
    logic [DATA_W-1:0] scale;
    nl = eff_levels();
    ng = eff_gammas();
    foreach (ratio_mem[k]) ratio_mem[k] = '0;
    if (do_sort) begin
      for (int i = 0; i < nl; i++) order_mem[i] = LVL_W'(i);
      swapped = 1'b1;
      while (swapped) begin
        swapped = 1'b0;
        for (int i = 0; i + 1 < nl; i++) begin
          a = order_mem[i];
          b = order_mem[i+1];
          if (energy_mem[a] > energy_mem[b]) begin
            order_mem[i]   = b;
            order_mem[i+1] = a;
            swapped = 1'b1;
          end
        end
      end
    end
    for (int i = 1; i < nl; i++) begin
      li  = order_mem[i];
      sum = '0;
      for (int g = 0; g < ng; g++)
        if (gamma_mem[g].src_level == li) sum += gamma_weight(g);
      if (sum == 0) continue;
      for (int g = 0; g < ng; g++) begin
        if (gamma_mem[g].src_level != li) continue;
        ratio_mem[g*MAX_LEVELS + li] =
          ratio_div(64'(gamma_mem[g].intensity) << ONE_SHIFT, sum);
        lf    = gamma_mem[g].tgt_level;
        scale = ratio_div(gamma_weight(g), sum);
        for (int jj = 0; jj < ng; jj++) begin
          add = (64'(ratio_mem[jj*MAX_LEVELS + lf]) * 64'(scale)) >> FRAC_BITS;
          v   = 64'(ratio_mem[jj*MAX_LEVELS + li]) + add;
          ratio_mem[jj*MAX_LEVELS + li] = (v > 64'(RATIO_MAX)) ? RATIO_MAX : v[DATA_W-1:0];
        end
      end
    end
  endfunction

  // Expected result of one item, updating the shadow state
  function automatic result_t predict_branching(item_t it);
    result_t r;
    r = '0;
    case (it.operation)
      OP_LEVEL: begin
        if (it.level_index < eff_levels()) begin
          energy_mem[it.level_index] = it.level_energy;
        end else r.status = 1'b1;
      end
      OP_GAMMA: begin
        if (it.gamma_index < eff_gammas()) begin
          gamma_mem[it.gamma_index] = '{it.intensity, it.conversion_coeff,
                                        it.level_index, it.final_level};
        end else r.status = 1'b1;
      end
      OP_COMPUTE: walk_scheme(it.sort_first);
      default: begin
        if (it.level_index < eff_levels() && it.gamma_index < eff_gammas())
          r.ratio = ratio_mem[it.gamma_index*MAX_LEVELS + it.level_index];
        else r.status = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(op_e op, int lvl, int gi, int fl, logic [23:0] en,
                                    logic [23:0] inten, logic [23:0] cc, bit srt);
    item_t it;
    it.operation        = op;
    it.level_index      = LVL_W'(lvl);
    it.gamma_index      = GAM_W'(gi);
    it.final_level      = LVL_W'(fl);
    it.level_energy     = en;
    it.intensity        = inten;
    it.conversion_coeff = cc;
    it.sort_first       = srt;
    return it;
  endfunction

  function automatic logic [23:0] rand_data();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return 24'($urandom);
    endcase
  endfunction

  // Sender: bursts with random gaps
  task automatic send_item(input item_t it, output result_t r);
    int gap;
    item_if.valid            <= 1'b1;
    item_if.operation        <= it.operation;
    item_if.level_index      <= it.level_index;
    item_if.gamma_index      <= it.gamma_index;
    item_if.final_level      <= it.final_level;
    item_if.level_energy     <= it.level_energy;
    item_if.intensity        <= it.intensity;
    item_if.conversion_coeff <= it.conversion_coeff;
    item_if.sort_first       <= it.sort_first;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    r = predict_branching(it);
    pending_q.push_back(r);
    n_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send(input item_t it);
    result_t r;
    send_item(it, r);
  endtask

  // Hold off until every result is back
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    if (idx == CFG_LEVEL_COUNT) lvl_count = 9'(val);
    else if (idx == CFG_GAMMA_COUNT) gam_count = 10'(val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver with its own stall pattern, and the checker
  int stall_mode = 0;
  int stall_ctr  = 0;
  result_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_mismatch < 10)
          $display("unexpected result item: ratio=%h status=%b", res_if.ratio, res_if.status);
        n_mismatch++;
      end else begin
        exp_r = pending_q.pop_front();
        if (res_if.ratio !== exp_r.ratio || res_if.status !== exp_r.status) begin
          n_errors++;
          if (n_mismatch < 10)
            $display("mismatch: ratio exp %h got %h, status exp %b got %b",
                     exp_r.ratio, res_if.ratio, exp_r.status, res_if.status);
          n_mismatch++;
        end
      end
    end
    stall_ctr++;
    if (stall_ctr % 256 == 0) stall_mode = $urandom_range(0, 2);
    if (rst_ni === 1'b0) begin
      res_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 7) != 0);
        default: res_if.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("[cascade_branching_ratio_engine] ERROR");
      $finish;
    end
  end

  // Directed table
  typedef struct {
    bit      is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    int      cfg_val;
    item_t   it;
    bit      has_exp;
    result_t exp_r;
  } dir_row_t;

  dir_row_t dir_tbl[$];

  function automatic void add_row(item_t it, bit has_exp, result_t e);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_idx = CFG_LEVEL_COUNT;
    row.cfg_val = 0;
    row.it      = it;
    row.has_exp = has_exp;
    row.exp_r   = e;
    dir_tbl.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    dir_tbl.push_back(row);
  endfunction

  // Random phase: small well-formed scheme with a compute, or load/read noise
  task automatic run_phase(bit with_compute);
    int nl;
    int ng;
    int lc;
    int gc;
    int n;
    if (with_compute) begin
      lc = $urandom_range(2, 16);
      gc = $urandom_range(1, 32);
    end else begin
      case ($urandom_range(0, 5))
        0: lc = 0;
        1: lc = 1;
        2: lc = 256;
        3: lc = 511;
        default: lc = $urandom_range(0, 511);
      endcase
      case ($urandom_range(0, 5))
        0: gc = 0;
        1: gc = 512;
        2: gc = 1023;
        3: gc = 1;
        default: gc = $urandom_range(0, 1023);
      endcase
    end
    drain();
    write_cfg(CFG_LEVEL_COUNT, lc);
    write_cfg(CFG_GAMMA_COUNT, gc);
    nl = eff_levels();
    ng = eff_gammas();
    if (with_compute) begin
      for (int l = 0; l < nl; l++)
        send(mk_item(OP_LEVEL, l, $urandom, $urandom,
                     ($urandom_range(0, 1) ? 24'($urandom_range(0, 3)) : rand_data()),
                     $urandom, $urandom, $urandom));
      for (int g = 0; g < ng; g++)
        send(mk_item(OP_GAMMA, $urandom_range(0, nl - 1), g,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, nl - 1),
                     $urandom, rand_data(), rand_data(), $urandom));
      send(mk_item(OP_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom_range(0, 1)));
      n = $urandom_range(30, 60);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0)
          send(mk_item(op_e'($urandom_range(0, 1)), $urandom_range(nl, 255),
                       $urandom_range(ng, 511), $urandom, $urandom, $urandom,
                       $urandom, $urandom));
        else
          send(mk_item(OP_READ, $urandom_range(0, nl), $urandom_range(0, ng),
                       $urandom, $urandom, $urandom, $urandom, $urandom));
      end
    end else begin
      n = $urandom_range(60, 120);
      for (int k = 0; k < n; k++)
        send(mk_item(op_e'($urandom_range(0, 2) == 0 ? OP_READ : $urandom_range(0, 1)),
                     $urandom_range(0, 255), $urandom_range(0, 511), $urandom,
                     rand_data(), rand_data(), rand_data(), $urandom));
    end
  endtask

  result_t got_r;
  int      computes_left;
  int      phase_no;

  initial begin
    rst_ni                   <= 1'b0;
    item_if.valid            <= 1'b0;
    item_if.operation        <= OP_LEVEL;
    item_if.level_index      <= '0;
    item_if.gamma_index      <= '0;
    item_if.final_level      <= '0;
    item_if.level_energy     <= '0;
    item_if.intensity        <= '0;
    item_if.conversion_coeff <= '0;
    item_if.sort_first       <= 1'b0;
    cfg_if.valid             <= 1'b0;
    cfg_if.index             <= CFG_LEVEL_COUNT;
    cfg_if.data              <= '0;
    lvl_count   = '0;
    gam_count   = '0;
    n_errors    = 0;
    n_mismatch  = 0;
    n_sent      = 0;
    burst_left  = 5;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      order_mem[i]  = LVL_W'(i);
      energy_mem[i] = '0;
    end
    for (int g = 0; g < MAX_GAMMAS; g++) begin
      gamma_mem[g]  = '0;
    end
    foreach (ratio_mem[k]) ratio_mem[k] = '0;

    // Counts zero after reset, so indices are beyond range first
    add_row(mk_item(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, '{'0, 1'b1});
    add_row(mk_item(OP_LEVEL, 0, 0, 0, 24'h123456, 0, 0, 0), 1, '{'0, 1'b1});
    add_cfg(CFG_LEVEL_COUNT, 4);
    add_cfg(CFG_GAMMA_COUNT, 6);
    add_row(mk_item(OP_LEVEL, 0, 0, 0, 24'h000100, 0, 0, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_LEVEL, 1, 0, 0, 24'hFFFFFF, 0, 0, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_LEVEL, 2, 0, 0, 24'h000000, 0, 0, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_LEVEL, 3, 0, 0, 24'h800000, 0, 0, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_LEVEL, 255, 0, 0, 24'hFFFFFF, 0, 0, 0), 1, '{'0, 1'b1});
    add_row(mk_item(OP_GAMMA, 1, 0, 3, 0, 24'h000100, 24'h000000, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_GAMMA, 1, 1, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_GAMMA, 3, 2, 2, 0, 24'h010000, 24'h008000, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_GAMMA, 2, 3, 0, 0, 24'h000100, 24'h000000, 0), 1, '{'0, 1'b0});
    // level 0 carries only zero intensities: zero sum
    add_row(mk_item(OP_GAMMA, 0, 4, 255, 0, 24'h000000, 24'hFFFFFF, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_GAMMA, 0, 5, 3, 0, 24'h000000, 24'h000000, 1), 1, '{'0, 1'b0});
    add_row(mk_item(OP_GAMMA, 1, 6, 0, 0, 24'h000100, 0, 0), 1, '{'0, 1'b1});
    add_row(mk_item(OP_GAMMA, 1, 511, 0, 0, 24'h000100, 0, 0), 1, '{'0, 1'b1});
    add_row(mk_item(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1), 1, '{'0, 1'b0});
    add_row(mk_item(OP_READ, 1, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(OP_READ, 1, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(OP_READ, 3, 2, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(OP_READ, 1, 3, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(OP_READ, 4, 0, 0, 0, 0, 0, 0), 1, '{'0, 1'b1});
    add_row(mk_item(OP_READ, 0, 6, 0, 0, 0, 0, 0), 1, '{'0, 1'b1});
    // sorted order is kept by a compute without sort
    add_row(mk_item(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 1, '{'0, 1'b0});
    add_row(mk_item(OP_READ, 3, 0, 0, 0, 0, 0, 0), 0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        drain();
        write_cfg(dir_tbl[i].cfg_idx, dir_tbl[i].cfg_val);
      end else begin
        send_item(dir_tbl[i].it, got_r);
        if (dir_tbl[i].has_exp && got_r != dir_tbl[i].exp_r) begin
          n_errors++;
          if (n_mismatch < 10)
            $display("table row %0d: typed %h, predicted %h", i, dir_tbl[i].exp_r, got_r);
          n_mismatch++;
        end
      end
    end

    // Random part; computes are costly, so only a few
    computes_left = 4;
    phase_no      = 0;
    while (n_sent < ITEM_GOAL) begin
      if (computes_left > 0 && phase_no % 3 == 0) begin
        run_phase(1'b1);
        computes_left--;
      end else run_phase(1'b0);
      phase_no++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && pending_q.size() == 0)
      $display("[cascade_branching_ratio_engine] OK");
    else
      $display("[cascade_branching_ratio_engine] ERROR");
    $finish;
  end

endmodule
